>>> rtl/plat_pkg.sv
// ---------------------------------------------------------------------------
// Phase limit alarm tracker package
// Shared types, constants and register indexes for the alarm tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package plat_pkg;

	localparam int unsigned NumPhases  = 3;
	localparam int unsigned NumEvents  = 2 * NumPhases;
	localparam int unsigned FifoDepth  = 4;
	localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
	localparam int unsigned CfgDataW   = 20;
	localparam int unsigned CfgIndexW  = 2;
	localparam int unsigned DurW       = 27;
	localparam int unsigned ElapsedW   = 30;

	// Multiplying a quarter of the elapsed seconds by this and dropping 34 bits
	// gives the exact quotient by 60 for every 32-bit input.
	localparam logic [30:0] MinuteRecip = 31'd1145324613;
	localparam int unsigned MinuteShift = 34;

	typedef logic [31:0] sec_t;
	typedef logic [15:0] volt_t;
	typedef logic [19:0] amp_t;

	typedef enum logic [CfgIndexW-1:0] {
		CFG_VOLT_LIMIT = 2'd0,
		CFG_AMP_LIMIT  = 2'd1,
		CFG_VOLT_EN    = 2'd2,
		CFG_AMP_EN     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		volt_t volt_limit;
		amp_t  amp_limit;
		logic  volt_en;
		logic  amp_en;
	} cfg_t;

	// One queued sample: bits 0..2 of the masks are the voltage phases,
	// bits 3..5 the current phases.
	typedef struct packed {
		sec_t                          stamp;
		volt_t [NumPhases-1:0]         volt;
		amp_t  [NumPhases-1:0]         amp;
		logic  [NumEvents-1:0]         fire;
		logic  [NumEvents-1:0]         onset;
		sec_t  [NumEvents-1:0]         elapsed;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/plat_if.sv
// ---------------------------------------------------------------------------
// Alarm tracker channels
// Valid/ready channels for measurement samples and alarm records.
// ---------------------------------------------------------------------------
`default_nettype none

interface plat_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_seconds;
	logic [15:0] volt_a;
	logic [15:0] volt_b;
	logic [15:0] volt_c;
	logic [19:0] amp_a;
	logic [19:0] amp_b;
	logic [19:0] amp_c;

	modport source (output valid, now_seconds, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
		input ready);
	modport sink (input valid, now_seconds, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
		output ready);
endinterface

interface plat_record_if;
	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [1:0]  phase_index;
	logic        is_onset;
	logic [26:0] duration_minutes;
	logic [31:0] stamp_seconds;
	logic [15:0] snap_volt_a;
	logic [15:0] snap_volt_b;
	logic [15:0] snap_volt_c;
	logic [19:0] snap_amp_a;
	logic [19:0] snap_amp_b;
	logic [19:0] snap_amp_c;
	logic        final_of_sample;

	modport source (output valid, event_kind, phase_index, is_onset, duration_minutes,
		stamp_seconds, snap_volt_a, snap_volt_b, snap_volt_c, snap_amp_a, snap_amp_b,
		snap_amp_c, final_of_sample, input ready);
	modport sink (input valid, event_kind, phase_index, is_onset, duration_minutes,
		stamp_seconds, snap_volt_a, snap_volt_b, snap_volt_c, snap_amp_a, snap_amp_b,
		snap_amp_c, final_of_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/plat_front.sv
// ---------------------------------------------------------------------------
// Alarm tracker front end
// Accepts samples, steps the per-phase alarm state and queues the events.
// ---------------------------------------------------------------------------
`default_nettype none

module plat_front
	import plat_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	plat_sample_if.sink     sample,
	input  wire cfg_t       cfg,
	input  wire logic       full,
	output logic            push,
	output entry_t          push_entry
);

	logic [NumPhases-1:0]        volt_act_q, volt_pv_q, amp_act_q;
	sec_t [NumPhases-1:0]        volt_start_q, amp_start_q;
	logic [NumPhases-1:0]        volt_act_d, volt_pv_d, amp_act_d;
	sec_t [NumPhases-1:0]        volt_start_d, amp_start_d;
	logic                        accept;
	entry_t                      ent;

	assign sample.ready = !full;
	assign accept       = sample.valid && !full;

	always_comb begin
		sec_t  now;
		volt_t v;
		amp_t  a;
		logic  vfire, afire;
		now = sample.now_seconds;
		volt_act_d   = volt_act_q;
		volt_pv_d    = volt_pv_q;
		volt_start_d = volt_start_q;
		amp_act_d    = amp_act_q;
		amp_start_d  = amp_start_q;
		ent.stamp    = now;
		ent.volt     = '{sample.volt_c, sample.volt_b, sample.volt_a};
		ent.amp      = '{sample.amp_c, sample.amp_b, sample.amp_a};
		ent.fire     = '0;
		ent.onset    = '0;
		ent.elapsed  = '0;
		for (int i = 0; i < NumPhases; i++) begin
			v     = ent.volt[i];
			a     = ent.amp[i];
			vfire = 1'b0;
			afire = 1'b0;
			if (volt_act_q[i]) begin
				if (v > cfg.volt_limit) begin
					vfire = 1'b1;
					if (volt_pv_q[i] && now > volt_start_q[i])
						ent.elapsed[i] = now - volt_start_q[i];
					volt_act_d[i]   = 1'b0;
					volt_pv_d[i]    = 1'b0;
					volt_start_d[i] = '0;
				end
			end else if (v < cfg.volt_limit) begin
				if (volt_pv_q[i]) begin
					volt_act_d[i] = 1'b1;
					ent.onset[i]  = 1'b1;
					vfire         = 1'b1;
				end else begin
					volt_pv_d[i]    = 1'b1;
					volt_start_d[i] = now;
				end
			end
			if (amp_act_q[i]) begin
				if (a < cfg.amp_limit) begin
					afire = 1'b1;
					if (now > amp_start_q[i])
						ent.elapsed[NumPhases+i] = now - amp_start_q[i];
					amp_act_d[i] = 1'b0;
				end
			end else if (a > cfg.amp_limit) begin
				amp_act_d[i]             = 1'b1;
				amp_start_d[i]           = now;
				ent.onset[NumPhases+i]   = 1'b1;
				afire                    = 1'b1;
			end
			ent.fire[i]           = vfire && cfg.volt_en;
			ent.fire[NumPhases+i] = afire && cfg.amp_en;
		end
	end

	// A sample that raises no record still steps the state but is not queued.
	assign push       = accept && (ent.fire != '0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_act_q   <= '0;
			volt_pv_q    <= '0;
			volt_start_q <= '0;
			amp_act_q    <= '0;
			amp_start_q  <= '0;
		end else if (accept) begin
			volt_act_q   <= volt_act_d;
			volt_pv_q    <= volt_pv_d;
			volt_start_q <= volt_start_d;
			amp_act_q    <= amp_act_d;
			amp_start_q  <= amp_start_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/plat_fifo.sv
// ---------------------------------------------------------------------------
// Alarm tracker event queue
// Short queue of classified samples between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module plat_fifo
	import plat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output logic        full,
	output logic        empty
);

	entry_t [FifoDepth-1:0] mem_q;
	logic [FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FifoPtrW:0]      count_q;

	assign full  = (count_q == (FifoPtrW+1)'(FifoDepth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/plat_back.sv
// ---------------------------------------------------------------------------
// Alarm tracker back end
// Serialises the queued events into records and converts durations to minutes.
// ---------------------------------------------------------------------------
`default_nettype none

module plat_back
	import plat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   empty,
	input  wire entry_t head,
	output logic        pop,
	plat_record_if.source record
);

	logic [NumEvents-1:0]   done_q, pend, sel_bit;
	logic [2:0]             sel_idx;
	logic                   adv, issue, last;
	logic                   valid_s1, valid_s2;
	logic                   kind_s1, onset_s1, final_s1;
	logic [1:0]             phase_s1;
	logic [ElapsedW-1:0]    quarter_s1;
	sec_t                   stamp_s1;
	volt_t [NumPhases-1:0]  volt_s1;
	amp_t  [NumPhases-1:0]  amp_s1;
	logic [60:0]            prod;
	sec_t                   sel_elapsed;

	assign pend = head.fire & ~done_q;

	always_comb begin
		sel_idx = '0;
		for (int k = NumEvents - 1; k >= 0; k--) begin
			if (pend[k])
				sel_idx = 3'(k);
		end
	end

	assign sel_bit     = NumEvents'(1) << sel_idx;
	assign sel_elapsed = head.elapsed[sel_idx];
	assign last        = ((pend & ~sel_bit) == '0);
	assign adv         = !valid_s2 || record.ready;
	assign issue       = adv && !empty;
	assign pop         = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop)
				done_q <= '0;
			else if (issue)
				done_q <= done_q | sel_bit;
			if (adv) begin
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1    <= (sel_idx >= 3'(NumPhases));
			phase_s1   <= (sel_idx >= 3'(NumPhases)) ? 2'(sel_idx - 3'(NumPhases))
				: 2'(sel_idx);
			onset_s1   <= head.onset[sel_idx];
			final_s1   <= last;
			quarter_s1 <= sel_elapsed[31:2];
			stamp_s1   <= head.stamp;
			volt_s1    <= head.volt;
			amp_s1     <= head.amp;
		end
	end

	assign prod = {31'b0, quarter_s1} * {30'b0, MinuteRecip};

	always_ff @(posedge clk) begin
		if (adv) begin
			record.event_kind       <= kind_s1;
			record.phase_index      <= phase_s1;
			record.is_onset         <= onset_s1;
			record.duration_minutes <= prod[MinuteShift +: DurW];
			record.stamp_seconds    <= stamp_s1;
			record.snap_volt_a      <= volt_s1[0];
			record.snap_volt_b      <= volt_s1[1];
			record.snap_volt_c      <= volt_s1[2];
			record.snap_amp_a       <= amp_s1[0];
			record.snap_amp_b       <= amp_s1[1];
			record.snap_amp_c       <= amp_s1[2];
			record.final_of_sample  <= final_s1;
		end
	end

	assign record.valid = valid_s2;

endmodule

`default_nettype wire

>>> rtl/phase_limit_alarm_tracker_unit.sv
// A sample is taken whenever the queue has room; its alarm state is updated at
// once, so samples may follow in every cycle while the queue is not full.
// The first record of a sample passes through the queue, the s1 stage and the output
// register; the back end then gives one record per cycle while the record side is ready.
// The four-entry queue sets how far the front end may run ahead of the back end.
// Reset clears the alarm state, the queue and the pipeline and loads register defaults.
// ---------------------------------------------------------------------------
// Phase limit alarm tracker
// Per-phase voltage low and current over limit alarms with onset and recovery records.
// ---------------------------------------------------------------------------
`default_nettype none

module phase_limit_alarm_tracker_unit
	import plat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	plat_sample_if.sink               sample,
	plat_record_if.source             record,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   push, pop, full, empty;
	entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_limit <= '0;
			cfg_q.amp_limit  <= 20'd999999;
			cfg_q.volt_en    <= 1'b1;
			cfg_q.amp_en     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_VOLT_LIMIT: cfg_q.volt_limit <= cfg_data[15:0];
				CFG_AMP_LIMIT:  cfg_q.amp_limit  <= cfg_data;
				CFG_VOLT_EN:    cfg_q.volt_en    <= cfg_data[0];
				CFG_AMP_EN:     cfg_q.amp_en     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	plat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.cfg        (cfg_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	plat_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	plat_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.record (record)
	);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// Phase limit alarm tracker testbench
// Drives measurement samples through the alarm tracker under several register
// settings. A scoreboard predicts the voltage low and current over limit
// records of every sample and checks them in order against the record channel.
// ---------------------------------------------------------------------------

module tb_top
	import plat_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit  = 1000000;
	localparam int unsigned DrainCycles = 16;
	localparam int unsigned HoldCycles  = 250;
	localparam int unsigned SecPerMin   = 60;
	localparam int unsigned VoltTop     = 65535;
	localparam int unsigned AmpTop      = 999999;
	localparam logic        KIND_VOLT   = 1'b0;
	localparam logic        KIND_AMP    = 1'b1;

	typedef struct packed {
		sec_t                  now;
		volt_t [NumPhases-1:0] volt;
		amp_t  [NumPhases-1:0] amp;
	} sample_t;

	typedef struct packed {
		logic                  event_kind;
		logic [1:0]            phase_index;
		logic                  is_onset;
		logic [DurW-1:0]       duration_minutes;
		sec_t                  stamp_seconds;
		volt_t [NumPhases-1:0] snap_volt;
		amp_t  [NumPhases-1:0] snap_amp;
		logic                  final_of_sample;
	} alarm_rec_t;

	typedef enum int {
		LVL_BELOW,
		LVL_ABOVE,
		LVL_EQUAL,
		LVL_ANY
	} level_mode_t;

	class alarm_scoreboard;
		volt_t                 volt_limit;
		amp_t                  amp_limit;
		logic                  volt_en;
		logic                  amp_en;
		logic [NumPhases-1:0]  volt_active;
		logic [NumPhases-1:0]  volt_pending;
		sec_t [NumPhases-1:0]  volt_start;
		logic [NumPhases-1:0]  amp_active;
		sec_t [NumPhases-1:0]  amp_start;
		alarm_rec_t            expected_records[$];
		int                    errors;
		int                    samples_seen;
		int                    records_checked;
		int                    onsets_seen;

		function new();
			volt_limit      = '0;
			amp_limit       = amp_t'(AmpTop);
			volt_en         = 1'b1;
			amp_en          = 1'b1;
			volt_active     = '0;
			volt_pending    = '0;
			volt_start      = '0;
			amp_active      = '0;
			amp_start       = '0;
			errors          = 0;
			samples_seen    = 0;
			records_checked = 0;
			onsets_seen     = 0;
		endfunction

		function void set_register(cfg_index_t idx, logic [CfgDataW-1:0] data);
			case (idx)
				CFG_VOLT_LIMIT: volt_limit = data[15:0];
				CFG_AMP_LIMIT:  amp_limit  = data;
				CFG_VOLT_EN:    volt_en    = data[0];
				CFG_AMP_EN:     amp_en     = data[0];
				default: ;
			endcase
		endfunction

		function logic [DurW-1:0] minutes_between(sec_t now, sec_t start);
			sec_t diff;
			if (now <= start)
				return '0;
			diff = now - start;
			return DurW'(diff / SecPerMin);
		endfunction

		function alarm_rec_t make_record(logic kind, int phase, logic onset,
				logic [DurW-1:0] dur, sample_t s);
			alarm_rec_t r;
			r.event_kind       = kind;
			r.phase_index      = phase[1:0];
			r.is_onset         = onset;
			r.duration_minutes = dur;
			r.stamp_seconds    = s.now;
			r.snap_volt        = s.volt;
			r.snap_amp         = s.amp;
			r.final_of_sample  = 1'b0;
			return r;
		endfunction

		function void note_sample(sample_t s);
			alarm_rec_t      batch[$];
			logic            fire;
			logic            onset;
			logic [DurW-1:0] dur;
			samples_seen++;
			for (int i = 0; i < NumPhases; i++) begin
				fire  = 1'b0;
				onset = 1'b0;
				dur   = '0;
				if (volt_active[i]) begin
					if (s.volt[i] > volt_limit) begin
						if (volt_pending[i])
							dur = minutes_between(s.now, volt_start[i]);
						volt_active[i]  = 1'b0;
						volt_pending[i] = 1'b0;
						volt_start[i]   = '0;
						fire = 1'b1;
					end
				end else if (s.volt[i] < volt_limit) begin
					// The first low reading only arms the start time.
					if (volt_pending[i]) begin
						volt_active[i] = 1'b1;
						onset = 1'b1;
						fire  = 1'b1;
					end else begin
						volt_pending[i] = 1'b1;
						volt_start[i]   = s.now;
					end
				end
				if (fire && volt_en)
					batch.push_back(make_record(KIND_VOLT, i, onset, dur, s));
			end
			for (int i = 0; i < NumPhases; i++) begin
				fire  = 1'b0;
				onset = 1'b0;
				dur   = '0;
				if (amp_active[i]) begin
					if (s.amp[i] < amp_limit) begin
						dur = minutes_between(s.now, amp_start[i]);
						amp_active[i] = 1'b0;
						fire = 1'b1;
					end
				end else if (s.amp[i] > amp_limit) begin
					amp_active[i] = 1'b1;
					amp_start[i]  = s.now;
					onset = 1'b1;
					fire  = 1'b1;
				end
				if (fire && amp_en)
					batch.push_back(make_record(KIND_AMP, i, onset, dur, s));
			end
			if (batch.size() > 0)
				batch[batch.size()-1].final_of_sample = 1'b1;
			foreach (batch[k])
				expected_records.push_back(batch[k]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_record(alarm_rec_t got);
			alarm_rec_t want;
			if (expected_records.size() == 0) begin
				$error("record transfer with nothing expected: kind %0d phase %0d",
					got.event_kind, got.phase_index);
				errors++;
				return;
			end
			want = expected_records.pop_front();
			records_checked++;
			if (want.is_onset)
				onsets_seen++;
			compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
			compare_field("phase_index", 32'(want.phase_index), 32'(got.phase_index));
			compare_field("is_onset", 32'(want.is_onset), 32'(got.is_onset));
			compare_field("duration_minutes", 32'(want.duration_minutes),
				32'(got.duration_minutes));
			compare_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
			compare_field("snap_volt_a", 32'(want.snap_volt[0]), 32'(got.snap_volt[0]));
			compare_field("snap_volt_b", 32'(want.snap_volt[1]), 32'(got.snap_volt[1]));
			compare_field("snap_volt_c", 32'(want.snap_volt[2]), 32'(got.snap_volt[2]));
			compare_field("snap_amp_a", 32'(want.snap_amp[0]), 32'(got.snap_amp[0]));
			compare_field("snap_amp_b", 32'(want.snap_amp[1]), 32'(got.snap_amp[1]));
			compare_field("snap_amp_c", 32'(want.snap_amp[2]), 32'(got.snap_amp[2]));
			compare_field("final_of_sample", 32'(want.final_of_sample),
				32'(got.final_of_sample));
		endfunction

		function int outstanding();
			return expected_records.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_index_t           cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	plat_sample_if smp();
	plat_record_if rec();

	alarm_scoreboard sb;

	bit          send_idle;
	bit          recv_idle;
	bit          hold_request;
	int unsigned cycles;
	int          settings_used;
	volt_t       cur_vlim;
	amp_t        cur_alim;
	sec_t        cur_time;
	level_mode_t volt_mode[NumPhases];
	level_mode_t amp_mode[NumPhases];

	phase_limit_alarm_tracker_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.record    (rec),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("[phase_limit_alarm_tracker_unit] ERROR");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// The record side stalls at random and, on request, holds off for a long stretch.
	initial begin : record_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rec.ready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HoldCycles;
			end
			if (hold_left > 0) begin
				rec.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rec.ready <= 1'b0;
				stall_left--;
			end else begin
				rec.ready <= 1'b1;
				if (recv_idle && $urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : record_monitor
		alarm_rec_t got;
		if (arst_n === 1'b1 && rec.valid === 1'b1 && rec.ready === 1'b1) begin
			got.event_kind       = rec.event_kind;
			got.phase_index      = rec.phase_index;
			got.is_onset         = rec.is_onset;
			got.duration_minutes = rec.duration_minutes;
			got.stamp_seconds    = rec.stamp_seconds;
			got.snap_volt[0]     = rec.snap_volt_a;
			got.snap_volt[1]     = rec.snap_volt_b;
			got.snap_volt[2]     = rec.snap_volt_c;
			got.snap_amp[0]      = rec.snap_amp_a;
			got.snap_amp[1]      = rec.snap_amp_b;
			got.snap_amp[2]      = rec.snap_amp_c;
			got.final_of_sample  = rec.final_of_sample;
			sb.check_record(got);
		end
	end

	function automatic sample_t mk(sec_t t, volt_t va, volt_t vb, volt_t vc,
			amp_t aa, amp_t ab, amp_t ac);
		sample_t s;
		s.now     = t;
		s.volt[0] = va;
		s.volt[1] = vb;
		s.volt[2] = vc;
		s.amp[0]  = aa;
		s.amp[1]  = ab;
		s.amp[2]  = ac;
		return s;
	endfunction

	function automatic level_mode_t pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return LVL_BELOW;
		if (r < 80)
			return LVL_ABOVE;
		if (r < 85)
			return LVL_EQUAL;
		return LVL_ANY;
	endfunction

	function automatic int unsigned pick_level(level_mode_t m, int unsigned lim,
			int unsigned top);
		int unsigned span;
		case (m)
			LVL_BELOW: begin
				if (lim == 0)
					return 0;
				span = (lim < 50) ? lim : 50;
				return lim - $urandom_range(1, span);
			end
			LVL_ABOVE: begin
				if (lim >= top)
					return top;
				span = ((top - lim) < 50) ? (top - lim) : 50;
				return lim + $urandom_range(1, span);
			end
			LVL_EQUAL: return lim;
			default:   return $urandom_range(0, top);
		endcase
	endfunction

	// Levels keep their trend over a few samples so that alarms arm, rise and
	// recover; the clock mostly runs forward with the odd jump or step back.
	function automatic sample_t random_sample();
		sample_t s;
		int      r;
		r = $urandom_range(0, 19);
		if (r == 0)
			cur_time = $urandom;
		else if (r == 1)
			cur_time = cur_time - $urandom_range(0, 100);
		else if (r == 2)
			cur_time = cur_time + $urandom_range(60, 200000);
		else
			cur_time = cur_time + $urandom_range(0, 400);
		s.now = cur_time;
		for (int i = 0; i < NumPhases; i++) begin
			if ($urandom_range(0, 2) == 0)
				volt_mode[i] = pick_mode();
			if ($urandom_range(0, 2) == 0)
				amp_mode[i] = pick_mode();
			s.volt[i] = volt_t'(pick_level(volt_mode[i], 32'(cur_vlim), VoltTop));
			s.amp[i]  = amp_t'(pick_level(amp_mode[i], 32'(cur_alim), AmpTop));
		end
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.now_seconds <= s.now;
		smp.volt_a      <= s.volt[0];
		smp.volt_b      <= s.volt[1];
		smp.volt_c      <= s.volt[2];
		smp.amp_a       <= s.amp[0];
		smp.amp_b       <= s.amp[1];
		smp.amp_c       <= s.amp[2];
		smp.valid       <= 1'b1;
		do @(posedge clk); while (smp.ready !== 1'b1);
		sb.note_sample(s);
	endtask

	// Samples without records may still be in flight when the last record has
	// gone, hence the extra cycles after the expectation queue has emptied.
	task automatic go_idle();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic apply_config(volt_t vlim, amp_t alim, logic ven, logic aen);
		write_reg(CFG_VOLT_LIMIT, CfgDataW'(vlim));
		write_reg(CFG_AMP_LIMIT, alim);
		write_reg(CFG_VOLT_EN, CfgDataW'(ven));
		write_reg(CFG_AMP_EN, CfgDataW'(aen));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_vlim = vlim;
		cur_alim = alim;
		settings_used++;
	endtask

	initial begin : stimulus
		int     n_items;
		volt_t  vlim;
		amp_t   alim;
		logic   ven;
		logic   aen;

		sb              = new();
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_VOLT_LIMIT;
		cfg_data        = '0;
		smp.valid       = 1'b0;
		smp.now_seconds = '0;
		smp.volt_a      = '0;
		smp.volt_b      = '0;
		smp.volt_c      = '0;
		smp.amp_a       = '0;
		smp.amp_b       = '0;
		smp.amp_c       = '0;
		send_idle       = 1'b1;
		recv_idle       = 1'b1;
		hold_request    = 1'b0;
		settings_used   = 1;
		cur_vlim        = '0;
		cur_alim        = amp_t'(AmpTop);
		cur_time        = '0;
		for (int i = 0; i < NumPhases; i++) begin
			volt_mode[i] = LVL_ANY;
			amp_mode[i]  = LVL_ANY;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: no voltage can fall below its limit and no current here exceeds its limit.
		send_sample(mk(32'd0, 16'd0, 16'd0, 16'd0, 20'd999999, 20'd999999, 20'd999999));
		send_sample(mk(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd0, 20'd0, 20'd0));

		go_idle();
		apply_config(16'd1000, 20'd5000, 1'b1, 1'b1);
		send_sample(mk(32'd100, 16'd500, 16'd2000, 16'd500, 20'd6000, 20'd100, 20'd5000));
		send_sample(mk(32'd100, 16'd500, 16'd500, 16'd500, 20'd6000, 20'd100, 20'd5000));
		// Recoveries with the clock behind the start time.
		send_sample(mk(32'd50, 16'd2000, 16'd2000, 16'd2000, 20'd0, 20'd100, 20'd5000));
		// Levels equal to the limits change nothing.
		send_sample(mk(32'd4000, 16'd1000, 16'd1000, 16'd1000, 20'd5000, 20'd5000, 20'd5000));
		send_sample(mk(32'd4000, 16'd1000, 16'd0, 16'd1000, 20'd5000, 20'd5000, 20'd5001));
		send_sample(mk(32'd4000, 16'd1000, 16'hFFFF, 16'd1000, 20'd4999, 20'd5000, 20'd4999));
		send_sample(mk(32'd7599, 16'd999, 16'd999, 16'd999, 20'd0, 20'd0, 20'd0));
		// Six onsets in one sample, then six recoveries; the current ones span the widest time.
		send_sample(mk(32'd0, 16'd0, 16'd0, 16'd0, 20'd999999, 20'd999999, 20'd999999));
		send_sample(mk(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd0, 20'd0, 20'd0));

		// Suppressed kinds keep tracking their state.
		go_idle();
		apply_config(16'd1000, 20'd5000, 1'b0, 1'b1);
		send_sample(mk(32'd10, 16'd0, 16'd0, 16'd0, 20'd9000, 20'd0, 20'd0));
		send_sample(mk(32'd20, 16'd0, 16'd0, 16'd0, 20'd9000, 20'd0, 20'd0));
		go_idle();
		apply_config(16'd1000, 20'd5000, 1'b1, 1'b0);
		send_sample(mk(32'd200, 16'd2000, 16'd0, 16'd2000, 20'd0, 20'd0, 20'd0));

		// Limits at the ends of their ranges.
		go_idle();
		apply_config(16'hFFFF, 20'd0, 1'b1, 1'b1);
		send_sample(mk(32'd300, 16'd0, 16'hFFFF, 16'hFFFE, 20'd1, 20'd0, 20'd999999));
		send_sample(mk(32'd400, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0, 20'd0));

		cur_time = 32'd1000;
		for (int p = 0; p < 7; p++) begin
			vlim      = volt_t'($urandom_range(1, VoltTop - 1));
			alim      = amp_t'($urandom_range(1, AmpTop - 1));
			ven       = 1'b1;
			aen       = 1'b1;
			n_items   = 55;
			send_idle = 1'b1;
			recv_idle = 1'b1;
			case (p)
				0: begin
					send_idle = 1'b0;
					recv_idle = 1'b0;
				end
				2: ven = 1'b0;
				3: aen = 1'b0;
				4: begin
					vlim    = volt_t'(VoltTop);
					alim    = '0;
					n_items = 40;
				end
				5: begin
					vlim    = '0;
					alim    = amp_t'(AmpTop);
					ven     = 1'b0;
					aen     = 1'b0;
					n_items = 20;
				end
				default: ;
			endcase
			go_idle();
			apply_config(vlim, alim, ven, aen);
			for (int k = 0; k < n_items; k++) begin
				if (p == 1 && k == 20)
					hold_request = 1'b1;
				if (p == 1 && k == 35) begin
					smp.valid <= 1'b0;
					@(posedge clk);
					while (sb.outstanding() != 0)
						@(posedge clk);
				end
				send_sample(random_sample());
			end
		end

		go_idle();
		$display("Run covered %0d samples and %0d checked records (%0d onsets) over %0d settings.",
			sb.samples_seen, sb.records_checked, sb.onsets_seen, settings_used);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("[phase_limit_alarm_tracker_unit] OK");
		else
			$display("[phase_limit_alarm_tracker_unit] ERROR");
		$finish;
	end

endmodule
